// ===== design/pst_pkg.sv =====
// ---------------------------------------------------------------------------
// pst_pkg
// Shared types, codes and constants for the pump step-test PI autotuner.
// ---------------------------------------------------------------------------
package pst_pkg;

  localparam int PWM_BITS_DEF      = 8;
  localparam int PRESSURE_BITS_DEF = 14;
  localparam int DIV_W             = 64;
  localparam int SUM_W             = 36;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 16;

  localparam logic [63:0] TAU_NUM = 64'd63212;
  localparam logic [63:0] TAU_DEN = 64'd100000;

  // 63212/100000 = 15803/25000; divide by 25000 through a reciprocal multiply
  localparam logic [31:0] TGT_MUL   = 32'd15803;
  localparam logic [31:0] TGT_RND   = 32'd24999;
  localparam logic [63:0] TGT_RECIP = 64'd703687442;
  localparam int          TGT_SHIFT = 44;

  localparam logic [8:0] WAIT_SHORT = 9'd5;
  localparam logic [8:0] WAIT_MID   = 9'd100;
  localparam logic [8:0] WAIT_LONG  = 9'd500;

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_START  = 2'd1;
  localparam logic [1:0] CMD_CANCEL = 2'd2;
  localparam logic [1:0] CMD_QUERY  = 2'd3;

  localparam logic [3:0] ST_RUN       = 4'd0;
  localparam logic [3:0] ST_IDLE      = 4'd1;
  localparam logic [3:0] ST_DONE      = 4'd2;
  localparam logic [3:0] ST_CANCEL    = 4'd3;
  localparam logic [3:0] ST_VENT_TMO  = 4'd4;
  localparam logic [3:0] ST_NO_RISE   = 4'd5;
  localparam logic [3:0] ST_ZERO_MAX  = 4'd6;
  localparam logic [3:0] ST_RISE_TMO  = 4'd7;
  localparam logic [3:0] ST_BAD_GAINS = 4'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_PWM_FLOOR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_CEILING = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEADY      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_AVG_RUNS    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA      = 3'd6;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_VENT   = 3'd1,
    PH_RAMP   = 3'd2,
    PH_STEADY = 3'd3,
    PH_VENT2  = 3'd4,
    PH_RISE   = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    DV_TGT,
    DV_KP,
    DV_KI,
    DV_AVK,
    DV_AVI
  } div_sel_t;

  typedef enum logic [3:0] {
    C_IDLE, C_EVAL, C_TGT, C_TGT_W, C_MUL1, C_MUL2, C_KP, C_KP_W,
    C_KI, C_KI_W, C_FIN, C_AVK, C_AVK_W, C_AVI, C_AVI_W, C_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic     load;
    logic     eval;
    logic     tgt_mul;
    logic     mul1;
    logic     mul2;
    logic     div_go;
    logic     div_take;
    div_sel_t div_sel;
    logic     fin;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic need_tgt;
    logic need_gain;
    logic need_avg;
    logic div_done;
  } dp_stat_t;

  function automatic logic [31:0] sat32(input logic [63:0] v);
    sat32 = (v[63:32] != 32'd0) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

endpackage

// ===== design/pst_if.sv =====
// ---------------------------------------------------------------------------
// pst_sample_if / pst_result_if
// Valid/ready channels for commands and samples in, and results out.
// ---------------------------------------------------------------------------
interface pst_sample_if #(parameter int PRESSURE_BITS = 14);
  logic                     valid;
  logic                     ready;
  logic [1:0]               cmd;
  logic [PRESSURE_BITS-1:0] vacuum;
  logic [31:0]              time_ms;

  modport source(output valid, cmd, vacuum, time_ms, input ready);
  modport sink(input valid, cmd, vacuum, time_ms, output ready);
endinterface

interface pst_result_if #(parameter int PWM_BITS = 8);
  logic                valid;
  logic                ready;
  logic [PWM_BITS-1:0] pwm;
  logic                valve_open;
  logic [2:0]          phase;
  logic [3:0]          status;
  logic [3:0]          run_index;
  logic [8:0]          next_wait_ms;
  logic [31:0]         kp_q16;
  logic [31:0]         ki_q16;

  modport source(output valid, pwm, valve_open, phase, status, run_index, next_wait_ms,
                 kp_q16, ki_q16, input ready);
  modport sink(input valid, pwm, valve_open, phase, status, run_index, next_wait_ms,
               kp_q16, ki_q16, output ready);
endinterface

// ===== design/pump_step_test_pi_autotuner.sv =====
// ---------------------------------------------------------------------------
// pump_step_test_pi_autotuner
// Step-response lambda PI autotune sequencer for a vacuum pump.
// ---------------------------------------------------------------------------
// channel   dir  handshake      payload
// samples   in   valid/ready    cmd, vacuum, time_ms
// results   out  valid/ready    pwm, valve_open, phase, status, run_index,
//                               next_wait_ms, kp_q16, ki_q16
// cfg       in   cfg_we         cfg_index, cfg_wdata
//
// One item at a time: the next item is accepted only after the last one
// has been loaded into the output register.
// Run ends are set by the shared 64-bit divider, one quotient bit a cycle.
// Reset is synchronous; a stalled result holds in the output register
// while the next item is accepted.
// ---------------------------------------------------------------------------
module pump_step_test_pi_autotuner import pst_pkg::*; #(
  parameter int PWM_BITS      = PWM_BITS_DEF,
  parameter int PRESSURE_BITS = PRESSURE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  pst_sample_if.sink            samples,
  pst_result_if.source          results,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  pst_dp #(
    .PWM_BITS      (PWM_BITS),
    .PRESSURE_BITS (PRESSURE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_cmd     (samples.cmd),
    .in_vacuum  (samples.vacuum),
    .in_time_ms (samples.time_ms),
    .cmd        (cmd),
    .stat       (stat),
    .o_pwm      (results.pwm),
    .o_valve    (results.valve_open),
    .o_phase    (results.phase),
    .o_status   (results.status),
    .o_run      (results.run_index),
    .o_wait     (results.next_wait_ms),
    .o_kp       (results.kp_q16),
    .o_ki       (results.ki_q16)
  );

endmodule

// ===== design/pst_div.sv =====
// ---------------------------------------------------------------------------
// pst_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module pst_div import pst_pkg::*; #(
  parameter int W = DIV_W
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         go,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic [W-1:0] quotient,
  output logic         done
);

  localparam int CW = $clog2(W + 1);

  logic [W:0]    rem;
  logic [W-1:0]  quo;
  logic [W-1:0]  dvs;
  logic [CW-1:0] cnt;
  logic [W:0]    shifted;
  logic          fits;

  assign shifted  = {rem[W-1:0], quo[W-1]};
  assign fits     = shifted >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        cnt <= CW'(W);
      end else if (cnt != '0) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (cnt != '0) begin
      rem <= fits ? (shifted - {1'b0, dvs}) : shifted;
      quo <= {quo[W-2:0], fits};
    end
  end

endmodule

// ===== design/pst_dp.sv =====
// ---------------------------------------------------------------------------
// pst_dp
// Datapath: configuration, phase state, gain arithmetic and result register.
// ---------------------------------------------------------------------------
module pst_dp import pst_pkg::*; #(
  parameter int PWM_BITS      = PWM_BITS_DEF,
  parameter int PRESSURE_BITS = PRESSURE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata,
  input  logic [1:0]               in_cmd,
  input  logic [PRESSURE_BITS-1:0] in_vacuum,
  input  logic [31:0]              in_time_ms,
  input  dp_cmd_t                  cmd,
  output dp_stat_t                 stat,
  output logic [PWM_BITS-1:0]      o_pwm,
  output logic                     o_valve,
  output logic [2:0]               o_phase,
  output logic [3:0]               o_status,
  output logic [3:0]               o_run,
  output logic [8:0]               o_wait,
  output logic [31:0]              o_kp,
  output logic [31:0]              o_ki
);

  localparam int P = PRESSURE_BITS;

  logic [PWM_BITS-1:0] floor_cfg, ceil_cfg;
  logic [7:0]          nt_cfg, ss_cfg;
  logic [15:0]         to_cfg, lam_cfg;
  logic [3:0]          avg_cfg;

  logic [1:0]  cmd_r;
  logic [P-1:0] v_r;
  logic [31:0] t_r;

  phase_t              phase, phase_next;
  logic [15:0]         sc, sc_next;
  logic [7:0]          stc, stc_next;
  logic [PWM_BITS-1:0] spwm, spwm_next;
  logic [P-1:0]        peak, peak_next, base, base_next, target, target_next;
  logic [P-1:0]        tdiff, tdiff_next;
  logic                tgt_up, tgt_up_next;
  logic [31:0]         tgt_n, tgt_n_next;
  logic [31:0]         rstart, rstart_next, tau, tau_next;
  logic [3:0]          run, run_next;
  logic [SUM_W-1:0]    kps, kps_next, kis, kis_next;
  logic [31:0]         gkp, gkp_next, gki, gki_next;
  logic [3:0]          status, status_next;
  logic                fresh, fresh_next;
  logic [63:0]         num, num_next, num1000, num1000_next, den2, den2_next;
  logic [31:0]         den1, den1_next, kp_r, kp_next, ki_r, ki_next;

  logic [16:0] sc_inc;
  logic        tmo;
  logic [8:0]  stc_inc;
  logic [31:0] tau_now;
  logic [15:0] lam_eff;
  logic [P-1:0] span;
  logic [63:0] tgt_prod;

  logic need_tgt, need_gain, need_avg, div_done;

  logic [DIV_W-1:0] div_a, div_b, div_q;

  assign sc_inc   = {1'b0, sc} + 17'd1;
  assign tmo      = sc_inc >= {1'b0, to_cfg};
  assign stc_inc  = {1'b0, stc} + 9'd1;
  assign tau_now  = t_r - rstart;
  assign lam_eff  = (lam_cfg == 16'd0) ? 16'd1 : lam_cfg;
  assign span     = peak - base;
  assign tgt_prod = 64'(tgt_n) * TGT_RECIP;

  always_ff @(posedge clk) begin
    if (rst) begin
      floor_cfg <= '0;
      ceil_cfg  <= PWM_BITS'(8'hFF);
      nt_cfg    <= 8'd8;
      to_cfg    <= 16'd1000;
      ss_cfg    <= 8'd20;
      avg_cfg   <= 4'd5;
      lam_cfg   <= 16'd768;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PWM_FLOOR:   floor_cfg <= PWM_BITS'(cfg_wdata[7:0]);
        CFG_PWM_CEILING: ceil_cfg  <= PWM_BITS'(cfg_wdata[7:0]);
        CFG_NOISE:       nt_cfg    <= cfg_wdata[7:0];
        CFG_TIMEOUT:     to_cfg    <= cfg_wdata;
        CFG_STEADY:      ss_cfg    <= cfg_wdata[7:0];
        CFG_AVG_RUNS:    avg_cfg   <= cfg_wdata[3:0];
        CFG_LAMBDA:      lam_cfg   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_cmd;
      v_r   <= in_vacuum;
      t_r   <= in_time_ms;
    end
  end

  always_comb begin
    div_a = '0;
    div_b = 64'd1;
    case (cmd.div_sel)
      DV_KP: begin
        div_a = num;
        div_b = 64'(den1);
      end
      DV_KI: begin
        div_a = num1000;
        div_b = den2;
      end
      DV_AVK: begin
        div_a = 64'(kps);
        div_b = 64'(avg_cfg);
      end
      DV_AVI: begin
        div_a = 64'(kis);
        div_b = 64'(avg_cfg);
      end
      default: ;
    endcase
  end

  pst_div #(.W(DIV_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (cmd.div_go),
    .dividend (div_a),
    .divisor  (div_b),
    .quotient (div_q),
    .done     (div_done)
  );

  assign need_avg = (run >= avg_cfg) && (avg_cfg != 4'd0);
  assign stat     = {need_tgt, need_gain, need_avg, div_done};

  always_comb begin
    logic end_steady;
    logic [P-1:0] pk;
    phase_next   = phase;
    sc_next      = sc;
    stc_next     = stc;
    spwm_next    = spwm;
    peak_next    = peak;
    base_next    = base;
    target_next  = target;
    tdiff_next   = tdiff;
    tgt_up_next  = tgt_up;
    tgt_n_next   = tgt_n;
    rstart_next  = rstart;
    tau_next     = tau;
    run_next     = run;
    kps_next     = kps;
    kis_next     = kis;
    gkp_next     = gkp;
    gki_next     = gki;
    status_next  = status;
    fresh_next   = fresh;
    num_next     = num;
    num1000_next = num1000;
    den1_next    = den1;
    den2_next    = den2;
    kp_next      = kp_r;
    ki_next      = ki_r;
    end_steady   = 1'b0;
    pk           = peak;
    need_tgt     = 1'b0;
    need_gain    = 1'b0;

    if (cmd.eval) begin
      status_next = ST_RUN;
      fresh_next  = 1'b0;
      case (cmd_r)
        CMD_START: begin
          kps_next   = '0;
          kis_next   = '0;
          run_next   = '0;
          phase_next = PH_VENT;
          sc_next    = '0;
          fresh_next = 1'b1;
        end
        CMD_CANCEL: begin
          if (phase == PH_IDLE) begin
            status_next = ST_IDLE;
          end else begin
            phase_next  = PH_IDLE;
            sc_next     = '0;
            status_next = ST_CANCEL;
          end
        end
        CMD_QUERY: begin
          status_next = (phase == PH_IDLE) ? ST_IDLE : ST_RUN;
        end
        default: begin
          case (phase)
            PH_VENT, PH_VENT2: begin
              if (32'(v_r) < 32'(nt_cfg)) begin
                fresh_next = 1'b1;
                sc_next    = '0;
                if (phase == PH_VENT) begin
                  phase_next = PH_RAMP;
                  spwm_next  = '0;
                  if (ceil_cfg == '0) begin
                    phase_next  = PH_IDLE;
                    status_next = ST_NO_RISE;
                  end
                end else begin
                  base_next   = v_r;
                  tgt_up_next = peak >= v_r;
                  tdiff_next  = (peak >= v_r) ? (peak - v_r) : (v_r - peak);
                  rstart_next = t_r;
                  phase_next  = PH_RISE;
                  need_tgt    = 1'b1;
                end
              end else begin
                sc_next = sc_inc[15:0];
                if (tmo) begin
                  phase_next  = PH_IDLE;
                  sc_next     = '0;
                  status_next = ST_VENT_TMO;
                end
              end
            end
            PH_RAMP: begin
              if (32'(v_r) > (32'(nt_cfg) << 1)) begin
                phase_next = PH_STEADY;
                sc_next    = '0;
                peak_next  = '0;
                stc_next   = '0;
                fresh_next = 1'b1;
              end else if (32'(spwm) + 32'd1 >= 32'(ceil_cfg)) begin
                phase_next  = PH_IDLE;
                sc_next     = '0;
                status_next = ST_NO_RISE;
              end else begin
                spwm_next = spwm + PWM_BITS'(1);
              end
            end
            PH_STEADY: begin
              if (v_r > peak) begin
                pk       = v_r;
                stc_next = '0;
              end else begin
                end_steady = stc_inc > {1'b0, ss_cfg};
                stc_next   = stc_inc[8] ? 8'hFF : stc_inc[7:0];
              end
              peak_next = pk;
              if (!end_steady) begin
                sc_next    = sc_inc[15:0];
                end_steady = tmo;
              end
              if (end_steady) begin
                sc_next = '0;
                if (pk == '0) begin
                  phase_next  = PH_IDLE;
                  status_next = ST_ZERO_MAX;
                end else begin
                  phase_next = PH_VENT2;
                  fresh_next = 1'b1;
                end
              end
            end
            PH_RISE: begin
              if (v_r >= target) begin
                if (tau_now == 32'd0 || peak <= base) begin
                  phase_next  = PH_IDLE;
                  sc_next     = '0;
                  status_next = ST_BAD_GAINS;
                end else begin
                  tau_next  = tau_now;
                  need_gain = 1'b1;
                end
              end else begin
                sc_next = sc_inc[15:0];
                if (tmo) begin
                  phase_next  = PH_IDLE;
                  sc_next     = '0;
                  status_next = ST_RISE_TMO;
                end
              end
            end
            default: status_next = ST_IDLE;
          endcase
        end
      endcase
    end

    if (cmd.tgt_mul) begin
      tgt_n_next = 32'(tdiff) * TGT_MUL + (tgt_up ? TGT_RND : 32'd0);
    end

    if (cmd.mul1) begin
      den1_next = 32'(span) * 32'(lam_eff);
      num_next  = 64'(32'(ceil_cfg) - 32'(spwm)) << 28;
    end

    if (cmd.mul2) begin
      den2_next    = 64'(den1) * 64'(tau);
      num1000_next = (num << 10) - (num << 4) - (num << 3);
    end

    if (cmd.div_take) begin
      case (cmd.div_sel)
        DV_TGT:  target_next = tgt_up ? (base + P'(tgt_prod[63:TGT_SHIFT]))
                                      : (base - P'(tgt_prod[63:TGT_SHIFT]));
        DV_KP:   kp_next  = sat32(div_q);
        DV_KI:   ki_next  = sat32(div_q);
        DV_AVK:  gkp_next = sat32(div_q);
        DV_AVI:  gki_next = sat32(div_q);
        default: ;
      endcase
    end

    if (cmd.fin) begin
      sc_next = '0;
      if (run != 4'd0) begin
        kps_next = kps + SUM_W'(kp_r);
        kis_next = kis + SUM_W'(ki_r);
      end
      if (run >= avg_cfg) begin
        if (avg_cfg == 4'd0) begin
          gkp_next = '0;
          gki_next = '0;
        end
        phase_next  = PH_IDLE;
        status_next = ST_DONE;
        fresh_next  = 1'b0;
      end else begin
        run_next    = run + 4'd1;
        phase_next  = PH_VENT;
        status_next = ST_RUN;
        fresh_next  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_IDLE;
      sc     <= '0;
      stc    <= '0;
      spwm   <= '0;
      peak   <= '0;
      base   <= '0;
      target <= '0;
      rstart <= '0;
      run    <= '0;
      kps    <= '0;
      kis    <= '0;
      gkp    <= '0;
      gki    <= '0;
      status <= ST_IDLE;
      fresh  <= 1'b0;
    end else begin
      phase  <= phase_next;
      sc     <= sc_next;
      stc    <= stc_next;
      spwm   <= spwm_next;
      peak   <= peak_next;
      base   <= base_next;
      target <= target_next;
      rstart <= rstart_next;
      run    <= run_next;
      kps    <= kps_next;
      kis    <= kis_next;
      gkp    <= gkp_next;
      gki    <= gki_next;
      status <= status_next;
      fresh  <= fresh_next;
    end
  end

  always_ff @(posedge clk) begin
    tdiff   <= tdiff_next;
    tgt_up  <= tgt_up_next;
    tgt_n   <= tgt_n_next;
    tau     <= tau_next;
    num     <= num_next;
    num1000 <= num1000_next;
    den1    <= den1_next;
    den2    <= den2_next;
    kp_r    <= kp_next;
    ki_r    <= ki_next;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_phase  <= phase;
      o_status <= status;
      o_run    <= run;
      o_kp     <= gkp;
      o_ki     <= gki;
      case (phase)
        PH_VENT, PH_VENT2: begin
          o_pwm   <= floor_cfg;
          o_valve <= 1'b1;
          o_wait  <= fresh ? WAIT_SHORT : WAIT_MID;
        end
        PH_RAMP: begin
          o_pwm   <= spwm;
          o_valve <= 1'b0;
          o_wait  <= WAIT_SHORT;
        end
        PH_STEADY: begin
          o_pwm   <= ceil_cfg;
          o_valve <= 1'b0;
          o_wait  <= fresh ? WAIT_SHORT : WAIT_LONG;
        end
        PH_RISE: begin
          o_pwm   <= ceil_cfg;
          o_valve <= 1'b0;
          o_wait  <= fresh ? WAIT_SHORT : WAIT_MID;
        end
        default: begin
          o_pwm   <= floor_cfg;
          o_valve <= 1'b0;
          o_wait  <= WAIT_LONG;
        end
      endcase
    end
  end

endmodule

// ===== design/pst_ctrl.sv =====
// ---------------------------------------------------------------------------
// pst_ctrl
// Sequencer: accepts an item, steps the datapath, hands off the result.
// ---------------------------------------------------------------------------
module pst_ctrl import pst_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= C_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.div_sel = DV_TGT;
    unique case (state)
      C_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = C_EVAL;
        end
      end
      C_EVAL: begin
        cmd.eval = 1'b1;
        if (stat.need_tgt) begin
          state_next = C_TGT;
        end else if (stat.need_gain) begin
          state_next = C_MUL1;
        end else begin
          state_next = C_DONE;
        end
      end
      C_TGT: begin
        cmd.tgt_mul = 1'b1;
        state_next  = C_TGT_W;
      end
      C_TGT_W: begin
        cmd.div_take = 1'b1;
        state_next   = C_DONE;
      end
      C_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = C_MUL2;
      end
      C_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = C_KP;
      end
      C_KP: begin
        cmd.div_sel = DV_KP;
        cmd.div_go  = 1'b1;
        state_next  = C_KP_W;
      end
      C_KP_W: begin
        cmd.div_sel = DV_KP;
        if (stat.div_done) begin
          cmd.div_take = 1'b1;
          state_next   = C_KI;
        end
      end
      C_KI: begin
        cmd.div_sel = DV_KI;
        cmd.div_go  = 1'b1;
        state_next  = C_KI_W;
      end
      C_KI_W: begin
        cmd.div_sel = DV_KI;
        if (stat.div_done) begin
          cmd.div_take = 1'b1;
          state_next   = C_FIN;
        end
      end
      C_FIN: begin
        cmd.fin    = 1'b1;
        state_next = stat.need_avg ? C_AVK : C_DONE;
      end
      C_AVK: begin
        cmd.div_sel = DV_AVK;
        cmd.div_go  = 1'b1;
        state_next  = C_AVK_W;
      end
      C_AVK_W: begin
        cmd.div_sel = DV_AVK;
        if (stat.div_done) begin
          cmd.div_take = 1'b1;
          state_next   = C_AVI;
        end
      end
      C_AVI: begin
        cmd.div_sel = DV_AVI;
        cmd.div_go  = 1'b1;
        state_next  = C_AVI_W;
      end
      C_AVI_W: begin
        cmd.div_sel = DV_AVI;
        if (stat.div_done) begin
          cmd.div_take = 1'b1;
          state_next   = C_DONE;
        end
      end
      C_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = C_IDLE;
        end
      end
      default: state_next = C_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_eval_after_accept: assert property (@(posedge clk) disable iff (rst)
    (state == C_EVAL) |-> $past(state == C_IDLE))
    else $error("eval not preceded by accept");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    stat.div_done |-> (state == C_KP_W || state == C_KI_W ||
                       state == C_AVK_W || state == C_AVI_W))
    else $error("divider finished outside a wait state");

  a_div_latency: assert property (@(posedge clk) disable iff (rst)
    cmd.div_go |=> !stat.div_done)
    else $error("divider done one cycle after start");
`endif

endmodule
